[design/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the buddy tree allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check that is switched off while reset is high.
`define ASSERT_CHK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds while reset is high.
`define ASSERT_CHK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CHK(label, clk, rst, prop, msg)

`define ASSERT_CHK_ALWAYS(label, clk, prop, msg)

`endif

`endif

[design/bta_pkg.sv]
// Shared constants, control word types and the microprogram of the buddy tree allocator.
`timescale 1ns / 1ps
`default_nettype none

package bta_pkg;

  localparam int TOTAL_UNITS_DEF = 64;
  localparam int LAYER_COUNT_DEF = 7;

  localparam int NODE_W  = 64;
  localparam int ADDR_W  = 6;
  localparam int LAYER_W = 3;
  localparam int SIZE_W  = 8;
  localparam int STEP_W  = 5;
  localparam int OP_W    = 4;
  localparam int COND_W  = 3;

  // Datapath operations.
  localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
  localparam logic [OP_W-1:0] OP_SIZE    = 4'd1;
  localparam logic [OP_W-1:0] OP_FIND    = 4'd2;
  localparam logic [OP_W-1:0] OP_TAKE    = 4'd3;
  localparam logic [OP_W-1:0] OP_UP      = 4'd4;
  localparam logic [OP_W-1:0] OP_CLR     = 4'd5;
  localparam logic [OP_W-1:0] OP_RESTORE = 4'd6;
  localparam logic [OP_W-1:0] OP_DOWN    = 4'd7;
  localparam logic [OP_W-1:0] OP_RECORD  = 4'd8;
  localparam logic [OP_W-1:0] OP_EMIT    = 4'd9;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 4'd10;
  localparam logic [OP_W-1:0] OP_SET     = 4'd11;
  localparam logic [OP_W-1:0] OP_CHECK   = 4'd12;
  localparam logic [OP_W-1:0] OP_MERGE   = 4'd13;

  // Jump conditions.
  localparam logic [COND_W-1:0] C_NONE   = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS = 3'd1;
  localparam logic [COND_W-1:0] C_FAIL   = 3'd2;
  localparam logic [COND_W-1:0] C_FREE   = 3'd3;
  localparam logic [COND_W-1:0] C_TOP    = 3'd4;
  localparam logic [COND_W-1:0] C_BOTTOM = 3'd5;

  // Program addresses.
  localparam logic [STEP_W-1:0] ST_SIZE      = 5'd0;
  localparam logic [STEP_W-1:0] ST_FIND      = 5'd1;
  localparam logic [STEP_W-1:0] ST_TAKE      = 5'd2;
  localparam logic [STEP_W-1:0] ST_A_UP      = 5'd3;
  localparam logic [STEP_W-1:0] ST_A_UPCLR   = 5'd4;
  localparam logic [STEP_W-1:0] ST_A_REST    = 5'd5;
  localparam logic [STEP_W-1:0] ST_A_DOWN    = 5'd6;
  localparam logic [STEP_W-1:0] ST_A_DNCLR   = 5'd7;
  localparam logic [STEP_W-1:0] ST_RECORD    = 5'd8;
  localparam logic [STEP_W-1:0] ST_EMIT      = 5'd9;
  localparam logic [STEP_W-1:0] ST_LOOKUP    = 5'd10;
  localparam logic [STEP_W-1:0] ST_F_REST    = 5'd11;
  localparam logic [STEP_W-1:0] ST_F_SET     = 5'd12;
  localparam logic [STEP_W-1:0] ST_F_DOWN    = 5'd13;
  localparam logic [STEP_W-1:0] ST_F_DNSET   = 5'd14;
  localparam logic [STEP_W-1:0] ST_F_REST2   = 5'd15;
  localparam logic [STEP_W-1:0] ST_F_CHECK   = 5'd16;
  localparam logic [STEP_W-1:0] ST_F_MERGE   = 5'd17;
  localparam logic [STEP_W-1:0] ST_DONE      = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctrl_t;

  typedef struct packed {
    logic fail;
    logic free;
    logic top;
    logic bottom;
  } cond_t;

  function automatic ctrl_t cw(input logic [OP_W-1:0] op, input logic [COND_W-1:0] cond,
                               input logic [STEP_W-1:0] target, input logic last);
    ctrl_t c;
    c.op     = op;
    c.cond   = cond;
    c.target = target;
    c.last   = last;
    return c;
  endfunction

  // The control store: one word per step.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    case (step)
      ST_SIZE:    c = cw(OP_SIZE,    C_FREE,   ST_LOOKUP,  1'b0);
      ST_FIND:    c = cw(OP_FIND,    C_FAIL,   ST_EMIT,    1'b0);
      ST_TAKE:    c = cw(OP_TAKE,    C_FAIL,   ST_EMIT,    1'b0);
      ST_A_UP:    c = cw(OP_UP,      C_TOP,    ST_A_REST,  1'b0);
      ST_A_UPCLR: c = cw(OP_CLR,     C_ALWAYS, ST_A_UP,    1'b0);
      ST_A_REST:  c = cw(OP_RESTORE, C_NONE,   ST_SIZE,    1'b0);
      ST_A_DOWN:  c = cw(OP_DOWN,    C_BOTTOM, ST_RECORD,  1'b0);
      ST_A_DNCLR: c = cw(OP_CLR,     C_ALWAYS, ST_A_DOWN,  1'b0);
      ST_RECORD:  c = cw(OP_RECORD,  C_NONE,   ST_SIZE,    1'b0);
      ST_EMIT:    c = cw(OP_EMIT,    C_NONE,   ST_SIZE,    1'b1);
      ST_LOOKUP:  c = cw(OP_LOOKUP,  C_NONE,   ST_SIZE,    1'b0);
      ST_F_REST:  c = cw(OP_RESTORE, C_FAIL,   ST_DONE,    1'b0);
      ST_F_SET:   c = cw(OP_SET,     C_NONE,   ST_SIZE,    1'b0);
      ST_F_DOWN:  c = cw(OP_DOWN,    C_BOTTOM, ST_F_REST2, 1'b0);
      ST_F_DNSET: c = cw(OP_SET,     C_ALWAYS, ST_F_DOWN,  1'b0);
      ST_F_REST2: c = cw(OP_RESTORE, C_NONE,   ST_SIZE,    1'b0);
      ST_F_CHECK: c = cw(OP_CHECK,   C_TOP,    ST_DONE,    1'b0);
      ST_F_MERGE: c = cw(OP_MERGE,   C_ALWAYS, ST_F_CHECK, 1'b0);
      ST_DONE:    c = cw(OP_NOP,     C_NONE,   ST_SIZE,    1'b1);
      default:    c = cw(OP_NOP,     C_NONE,   ST_SIZE,    1'b1);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[design/buddy_tree_allocator.sv]
// Top level of the buddy tree allocator: request port, tree datapath and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Buddy allocator over TOTAL_UNITS units kept as LAYER_COUNT layers of free bits;
// layer k holds one bit per aligned block of 2^(k-1) units, and a set bit means the
// whole block is free. An allocate request (kind 0) of request_size units picks the
// layer that fits the size rounded up to a power of two, takes its lowest free node,
// clears that node together with every ancestor and descendant, records the layer
// for the start address, and returns one result transfer carrying block_address.
// A size of zero, a size above TOTAL_UNITS or a full layer returns alloc_failed with
// block_address zero and leaves the tree as it was. A free request (kind 1) produces
// no result transfer: it looks up the layer recorded for free_address, sets that node
// and its descendants, and then walks upward setting each parent whose two children
// are free. Freeing an address that was never handed out is not supported. Requests
// are handled one at a time by a small microprogram that visits one tree layer per
// step or per pair of steps; a new request is taken only once the program of the
// last one has ended. An allocate with an invalid size jumps from its find step
// straight to its result step, one that finds its layer full jumps there from its
// take step, and a free of an address without a valid record jumps from its
// restore step to the done step. A result waits in its own output register, so a
// stalled result only holds the block when the following allocate reaches its
// final step.
module buddy_tree_allocator #(
  parameter int TOTAL_UNITS = bta_pkg::TOTAL_UNITS_DEF,
  parameter int LAYER_COUNT = bta_pkg::LAYER_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        kind,
  input  wire logic [bta_pkg::SIZE_W-1:0]  request_size,
  input  wire logic [bta_pkg::ADDR_W-1:0]  free_address,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bta_pkg::ADDR_W-1:0]       block_address,
  output logic                             alloc_failed
);

  localparam int NODE_W  = bta_pkg::NODE_W;
  localparam int ADDR_W  = bta_pkg::ADDR_W;
  localparam int LAYER_W = bta_pkg::LAYER_W;
  localparam int SIZE_W  = bta_pkg::SIZE_W;
  localparam int LIDX_W  = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int ADDRS   = 1 << ADDR_W;

  // Mask of the nodes that exist in layer k (1 based); layer 0 has none.
  function automatic logic [NODE_W-1:0] layer_mask(input logic [LAYER_W-1:0] k);
    logic [6:0]        w;
    logic [NODE_W-1:0] m;
    w = 7'(TOTAL_UNITS) >> (k - 3'd1);
    if (k == '0) begin
      m = '0;
    end else if (w[6]) begin
      m = '1;
    end else begin
      m = (NODE_W'(1) << w[5:0]) - NODE_W'(1);
    end
    return m;
  endfunction

  // Sequencer interface.
  bta_pkg::ctrl_t ctrl;
  bta_pkg::cond_t cond;
  logic           busy;
  logic           hold;
  logic           run;
  logic           accept;

  // Latched request.
  logic              kind_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] faddr_q;

  // Datapath registers.
  logic [LAYER_W-1:0] lyr;
  logic [LAYER_W-1:0] blayer;
  logic [ADDR_W-1:0]  node;
  logic [ADDR_W-1:0]  addr;
  logic [NODE_W-1:0]  span;
  logic               fail;
  logic               merge;

  // Tree state and per-address layer record.
  logic [NODE_W-1:0]  fl [LAYER_COUNT];
  logic [LAYER_W-1:0] bl [ADDRS];
  logic [LAYER_W-1:0] bl_rd;

  // Combinational datapath.
  logic               lyr_ok;
  logic [LIDX_W-1:0]  lidx;
  logic [NODE_W-1:0]  cur;
  logic [NODE_W-1:0]  mask_cur;
  logic [NODE_W-1:0]  bits;
  logic [NODE_W-1:0]  low;
  logic [ADDR_W-1:0]  enc;
  logic [NODE_W-1:0]  span_up;
  logic [NODE_W-1:0]  span_down;
  logic [NODE_W-1:0]  pair_and;
  logic [SIZE_W-1:0]  szm1;
  logic [3:0]         ceil_lg;
  logic [3:0]         size_layer;
  logic               size_bad;
  logic               lk_bad;
  logic               fl_we;
  logic [NODE_W-1:0]  fl_wdata;

  // The block takes a request only between programs.
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  // The final allocate step waits while the previous result is still held by the consumer.
  assign hold = (ctrl.op == bta_pkg::OP_EMIT) && out_valid && out_stall;
  assign run  = busy && !hold;

  assign cond.fail   = fail;
  assign cond.free   = kind_q;
  assign cond.top    = (lyr == LAYER_W'(LAYER_COUNT));
  assign cond.bottom = (lyr == LAYER_W'(1));

  bta_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .hold  (hold),
    .cond  (cond),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q  <= kind;
      size_q  <= request_size;
      faddr_q <= free_address;
    end
  end

  // Current layer read port: one layer is visited per step.
  always_comb begin
    lyr_ok   = (lyr != '0) && (lyr <= LAYER_W'(LAYER_COUNT));
    lidx     = LIDX_W'(lyr - 3'd1);
    cur      = lyr_ok ? fl[lidx] : '0;
    mask_cur = layer_mask(lyr);
    bits     = cur & mask_cur;
    low      = bits & (~bits + NODE_W'(1));
  end

  // Index of the one-hot span.
  always_comb begin
    enc = '0;
    for (int i = 0; i < NODE_W; i++) begin
      if (span[i]) begin
        enc = enc | ADDR_W'(i);
      end
    end
  end

  // Moving one layer up folds node pairs together; moving down splits each node in two.
  always_comb begin
    span_up  = '0;
    pair_and = '0;
    for (int i = 0; i < NODE_W / 2; i++) begin
      span_up[i]  = span[2*i] | span[2*i+1];
      pair_and[i] = cur[2*i] & cur[2*i+1];
    end
    for (int i = 0; i < NODE_W; i++) begin
      span_down[i] = span[i >> 1];
    end
  end

  // Layer that fits the request size rounded up to a power of two.
  always_comb begin
    szm1    = size_q - SIZE_W'(1);
    ceil_lg = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (szm1[i]) begin
        ceil_lg = 4'(i + 1);
      end
    end
    size_layer = (size_q <= SIZE_W'(1)) ? 4'd1 : ceil_lg + 4'd1;
    size_bad   = (size_q == '0) || (size_q > SIZE_W'(TOTAL_UNITS)) ||
                 (size_layer > 4'(LAYER_COUNT));
    lk_bad     = (bl_rd == '0) || (bl_rd > LAYER_W'(LAYER_COUNT));
  end

  // Write port of the layer store.
  always_comb begin
    fl_we    = 1'b0;
    fl_wdata = cur;
    if (ctrl.op inside {bta_pkg::OP_CLR, bta_pkg::OP_TAKE}) begin
      fl_we    = lyr_ok;
      fl_wdata = cur & ~span;
    end else if (ctrl.op == bta_pkg::OP_SET) begin
      fl_we    = lyr_ok;
      fl_wdata = cur | (span & mask_cur);
    end else if (ctrl.op == bta_pkg::OP_MERGE) begin
      fl_we    = lyr_ok && merge;
      fl_wdata = cur | (span & mask_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAYER_COUNT; i++) begin
        fl[i] <= layer_mask(LAYER_W'(i + 1));
      end
    end else if (run && fl_we) begin
      fl[lidx] <= fl_wdata;
    end
  end

  // Layer record, read every cycle at the latched free address.
  always_ff @(posedge clk) begin
    if (run && (ctrl.op == bta_pkg::OP_RECORD)) begin
      bl[addr] <= blayer;
    end
    bl_rd <= bl[faddr_q];
  end

  // Datapath operations selected by the control word.
  always_ff @(posedge clk) begin
    if (run) begin
      case (ctrl.op)
        bta_pkg::OP_SIZE: begin
          lyr    <= size_layer[LAYER_W-1:0];
          blayer <= size_layer[LAYER_W-1:0];
          fail   <= size_bad;
          addr   <= '0;
        end
        bta_pkg::OP_FIND: begin
          span <= low;
          if (bits == '0) begin
            fail <= 1'b1;
          end
        end
        bta_pkg::OP_TAKE: begin
          node <= enc;
          addr <= enc << (lyr - 3'd1);
        end
        bta_pkg::OP_UP: begin
          span <= span_up;
          lyr  <= lyr + 3'd1;
        end
        bta_pkg::OP_RESTORE: begin
          span <= NODE_W'(1) << node;
          lyr  <= blayer;
        end
        bta_pkg::OP_DOWN: begin
          span <= span_down;
          lyr  <= lyr - 3'd1;
        end
        bta_pkg::OP_LOOKUP: begin
          lyr    <= bl_rd;
          blayer <= bl_rd;
          node   <= faddr_q >> (bl_rd - 3'd1);
          fail   <= lk_bad;
        end
        bta_pkg::OP_CHECK: begin
          merge <= |(pair_and & span_up);
          span  <= span_up;
          lyr   <= lyr + 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: loaded by the final allocate step, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (run && (ctrl.op == bta_pkg::OP_EMIT)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run && (ctrl.op == bta_pkg::OP_EMIT)) begin
      block_address <= addr;
      alloc_failed  <= fail;
    end
  end

  `ASSERT_CHK_ALWAYS(a_reset_idle, clk, rst |=> (!busy && !out_valid), "not idle after reset")
  `ASSERT_CHK(a_emit_loads, clk, rst, (run && ctrl.op == bta_pkg::OP_EMIT) |=> out_valid, "result lost")
  `ASSERT_CHK(a_fail_zero, clk, rst, (out_valid && alloc_failed) |-> (block_address == '0), "failed result with address")
  `ASSERT_CHK(a_end_on_last, clk, rst, $fell(busy) |-> $past(ctrl.last), "program left early")
  `ASSERT_CHK(a_layer1_range, clk, rst, (fl[0] & ~layer_mask(3'd1)) == '0, "node beyond layer width")

endmodule

`default_nettype wire

[design/bta_seq.sv]
// Step counter and control store of the buddy tree allocator.
`timescale 1ns / 1ps
`default_nettype none

module bta_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic           hold,
  input  wire bta_pkg::cond_t cond,
  output logic                busy,
  output bta_pkg::ctrl_t      ctrl
);

  logic [bta_pkg::STEP_W-1:0] step;
  logic                       take_jump;

  assign ctrl = bta_pkg::ucode(step);

  always_comb begin
    case (ctrl.cond)
      bta_pkg::C_NONE:   take_jump = 1'b0;
      bta_pkg::C_ALWAYS: take_jump = 1'b1;
      bta_pkg::C_FAIL:   take_jump = cond.fail;
      bta_pkg::C_FREE:   take_jump = cond.free;
      bta_pkg::C_TOP:    take_jump = cond.top;
      bta_pkg::C_BOTTOM: take_jump = cond.bottom;
      default:           take_jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= bta_pkg::ST_SIZE;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        step <= bta_pkg::ST_SIZE;
      end
    end else if (!hold) begin
      if (ctrl.last) begin
        busy <= 1'b0;
      end else if (take_jump) begin
        step <= ctrl.target;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
